// File: rtl/core/gcbp_pkg.sv
// ----------------------------------------------------------------------------
// gcbp_pkg
// Types, tag codes and fixed field layouts for the GIF block structure parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gcbp_pkg;

  typedef enum logic [4:0] {
    PH_HDR, PH_LSD, PH_GTAB, PH_SELECT, PH_LABEL, PH_PT, PH_PT_LEN, PH_PT_DATA,
    PH_GCE, PH_APP, PH_APP_LEN, PH_APP_DATA, PH_COM_LEN, PH_COM_DATA, PH_IMD,
    PH_LTAB, PH_LZW, PH_IMG_LEN, PH_IMG_DATA, PH_AFTER_IMG, PH_ERR, PH_DONE
  } phase_t;

  // section codes
  localparam logic [3:0] SEC_HEADER  = 4'd0;
  localparam logic [3:0] SEC_SCREEN  = 4'd1;
  localparam logic [3:0] SEC_TABLE   = 4'd2;
  localparam logic [3:0] SEC_EXT     = 4'd3;
  localparam logic [3:0] SEC_PTEXT   = 4'd4;
  localparam logic [3:0] SEC_GCTRL   = 4'd5;
  localparam logic [3:0] SEC_APP     = 4'd6;
  localparam logic [3:0] SEC_COMMENT = 4'd7;
  localparam logic [3:0] SEC_IMGDESC = 4'd8;
  localparam logic [3:0] SEC_IMGDATA = 4'd9;
  localparam logic [3:0] SEC_TRAILER = 4'd10;
  localparam logic [3:0] SEC_ERROR   = 4'd11;
  localparam logic [3:0] SEC_DONE    = 4'd12;

  // field codes outside the fixed layouts
  localparam logic [3:0] FC_NONE       = 4'd0;
  localparam logic [3:0] FC_TAB_GLOBAL = 4'd0;
  localparam logic [3:0] FC_TAB_LOCAL  = 4'd1;
  localparam logic [3:0] FC_EXT_INTRO  = 4'd0;
  localparam logic [3:0] FC_EXT_LABEL  = 4'd1;
  localparam logic [3:0] FC_LZW_MIN    = 4'd0;
  // sub-block length code; payload is one above, terminator two above
  localparam logic [3:0] FC_PT_LEN     = 4'd9;
  localparam logic [3:0] FC_APP_LEN    = 4'd3;
  localparam logic [3:0] FC_COM_LEN    = 4'd0;
  localparam logic [3:0] FC_IMG_LEN    = 4'd1;
  localparam logic [3:0] FC_DATA_OFS   = 4'd1;
  localparam logic [3:0] FC_TERM_OFS   = 4'd2;

  // byte values
  localparam logic [7:0] BYTE_INTRO    = 8'h21;
  localparam logic [7:0] BYTE_TRAILER  = 8'h3b;
  localparam logic [7:0] LBL_PTEXT     = 8'h01;
  localparam logic [7:0] LBL_GCTRL     = 8'hf9;
  localparam logic [7:0] LBL_APP       = 8'hff;
  localparam logic [7:0] LBL_COMMENT   = 8'hfe;

  // last header position and last positions of the fixed layouts
  localparam logic [3:0] HDR_LAST = 4'd5;
  localparam logic [3:0] LSD_LAST = 4'd6;
  localparam logic [3:0] PT_LAST  = 4'd12;
  localparam logic [3:0] GCE_LAST = 4'd5;
  localparam logic [3:0] APP_LAST = 4'd11;
  localparam logic [3:0] IMD_LAST = 4'd9;
  localparam logic [3:0] LSD_PACKED_POS = 4'd4;
  localparam logic [3:0] IMD_PACKED_POS = 4'd9;

  // layout entry: [3:0] field code, [4] low byte, [5] high byte, [6] terminator
  localparam int KIND_LOW  = 4;
  localparam int KIND_HIGH = 5;
  localparam int KIND_TERM = 6;

  function automatic logic [6:0] lay_lsd(input logic [3:0] pos);
    logic [6:0] e;
    unique case (pos)
      4'd0: e = 7'h10;
      4'd1: e = 7'h20;
      4'd2: e = 7'h11;
      4'd3: e = 7'h21;
      4'd4: e = 7'h02;
      4'd5: e = 7'h03;
      4'd6: e = 7'h04;
      default: e = 7'h00;
    endcase
    return e;
  endfunction

  function automatic logic [6:0] lay_pt(input logic [3:0] pos);
    logic [6:0] e;
    unique case (pos)
      4'd0:  e = 7'h00;
      4'd1:  e = 7'h11;
      4'd2:  e = 7'h21;
      4'd3:  e = 7'h12;
      4'd4:  e = 7'h22;
      4'd5:  e = 7'h13;
      4'd6:  e = 7'h23;
      4'd7:  e = 7'h14;
      4'd8:  e = 7'h24;
      4'd9:  e = 7'h05;
      4'd10: e = 7'h06;
      4'd11: e = 7'h07;
      4'd12: e = 7'h08;
      default: e = 7'h00;
    endcase
    return e;
  endfunction

  function automatic logic [6:0] lay_gce(input logic [3:0] pos);
    logic [6:0] e;
    unique case (pos)
      4'd0: e = 7'h00;
      4'd1: e = 7'h01;
      4'd2: e = 7'h12;
      4'd3: e = 7'h22;
      4'd4: e = 7'h03;
      4'd5: e = 7'h44;
      default: e = 7'h00;
    endcase
    return e;
  endfunction

  function automatic logic [6:0] lay_app(input logic [3:0] pos);
    logic [6:0] e;
    if (pos == 4'd0) begin
      e = 7'h00;
    end else if (pos <= 4'd8) begin
      e = 7'h01;
    end else if (pos <= APP_LAST) begin
      e = 7'h02;
    end else begin
      e = 7'h00;
    end
    return e;
  endfunction

  function automatic logic [6:0] lay_imd(input logic [3:0] pos);
    logic [6:0] e;
    unique case (pos)
      4'd0: e = 7'h00;
      4'd1: e = 7'h11;
      4'd2: e = 7'h21;
      4'd3: e = 7'h12;
      4'd4: e = 7'h22;
      4'd5: e = 7'h13;
      4'd6: e = 7'h23;
      4'd7: e = 7'h14;
      4'd8: e = 7'h24;
      4'd9: e = 7'h05;
      default: e = 7'h00;
    endcase
    return e;
  endfunction

  // entry count of a colour table from a packed byte, zero when absent
  function automatic logic [8:0] table_size(input logic [7:0] packed_byte);
    logic [8:0] n;
    if (packed_byte[7]) begin
      n = 9'd2 << packed_byte[2:0];
    end else begin
      n = 9'd0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gif_container_block_parser.sv
// ----------------------------------------------------------------------------
// gif_container_block_parser
// Tags each byte of a GIF stream with its section, field and table position.
// ----------------------------------------------------------------------------
// an accepted byte's tag is registered and shows on the output in the next cycle
// throughput: one byte per cycle while the output is not stalled; the block state updates once per byte
// a waiting tag holds the input off; a new byte enters in the cycle it leaves
// reset (rst, synchronous): header phase, counters and sticky flags cleared,
// output empty
`default_nettype none

module gif_container_block_parser
  import gcbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       raw_byte,
  output logic [3:0]       section,
  output logic [3:0]       field_code,
  output logic [15:0]      field_value,
  output logic             value_done,
  output logic [7:0]       table_entry,
  output logic [1:0]       color_part,
  output logic             sub_block_data,
  output logic             chain_end,
  output logic             bad_label,
  output logic             stream_done
);

  phase_t      phase, phase_next;
  logic [3:0]  field_counter, field_counter_next;
  logic [7:0]  tab_entry, tab_entry_next;
  logic [1:0]  tab_part, tab_part_next;
  logic [8:0]  table_entries, table_entries_next;
  logic [7:0]  sub_block_left, sub_block_left_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic        error_latch, error_latch_next;
  logic        done_latch, done_latch_next;

  logic        accept;
  logic [7:0]  b;
  logic [6:0]  lay;
  logic [3:0]  lay_last;
  logic        lay_end;
  logic        tab_end;
  logic        blk_intro;

  logic [3:0]  t_section, t_code;
  logic [15:0] t_value;
  logic        t_done, t_sbd, t_cend;

  assign b         = data_byte;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign blk_intro = (b == BYTE_INTRO);
  assign tab_end   = (tab_part == 2'd2) && (({1'b0, tab_entry} + 9'd1) == table_entries);

  // layout entry for the current byte; a block start reads the first image field
  always_comb begin
    lay      = 7'h00;
    lay_last = 4'd0;
    unique case (phase)
      PH_LSD: begin
        lay      = lay_lsd(field_counter);
        lay_last = LSD_LAST;
      end
      PH_PT: begin
        lay      = lay_pt(field_counter);
        lay_last = PT_LAST;
      end
      PH_GCE: begin
        lay      = lay_gce(field_counter);
        lay_last = GCE_LAST;
      end
      PH_APP: begin
        lay      = lay_app(field_counter);
        lay_last = APP_LAST;
      end
      PH_IMD: begin
        lay      = lay_imd(field_counter);
        lay_last = IMD_LAST;
      end
      PH_SELECT, PH_AFTER_IMG: begin
        lay      = lay_imd(4'd0);
        lay_last = IMD_LAST;
      end
      default: begin
        lay      = 7'h00;
        lay_last = 4'd0;
      end
    endcase
  end

  assign lay_end = (field_counter == lay_last);

  // next state
  always_comb begin
    phase_next          = phase;
    field_counter_next  = field_counter;
    tab_entry_next      = tab_entry;
    tab_part_next       = tab_part;
    table_entries_next  = table_entries;
    sub_block_left_next = sub_block_left;
    low_byte_hold_next  = low_byte_hold;
    error_latch_next    = error_latch;
    done_latch_next     = done_latch;

    if (phase == PH_LSD || phase == PH_PT || phase == PH_GCE ||
        phase == PH_APP || phase == PH_IMD) begin
      if (lay[KIND_LOW]) begin
        low_byte_hold_next = b;
      end
      field_counter_next = lay_end ? 4'd0 : field_counter + 4'd1;
    end

    unique case (phase)
      PH_HDR: begin
        field_counter_next = field_counter + 4'd1;
        if (field_counter == HDR_LAST) begin
          field_counter_next = 4'd0;
          phase_next         = PH_LSD;
        end
      end
      PH_LSD: begin
        if (field_counter == LSD_PACKED_POS) begin
          table_entries_next = table_size(b);
        end
        if (lay_end) begin
          tab_entry_next = 8'd0;
          tab_part_next  = 2'd0;
          phase_next     = (table_entries != 9'd0) ? PH_GTAB : PH_SELECT;
        end
      end
      PH_GTAB, PH_LTAB: begin
        if (tab_part == 2'd2) begin
          tab_part_next  = 2'd0;
          tab_entry_next = tab_entry + 8'd1;
        end else begin
          tab_part_next  = tab_part + 2'd1;
        end
        if (tab_end) begin
          tab_part_next  = 2'd0;
          tab_entry_next = 8'd0;
          phase_next     = (phase == PH_GTAB) ? PH_SELECT : PH_LZW;
        end
      end
      PH_SELECT, PH_AFTER_IMG: begin
        if (phase == PH_AFTER_IMG && b == BYTE_TRAILER) begin
          done_latch_next = 1'b1;
          phase_next      = PH_DONE;
        end else if (blk_intro) begin
          phase_next = PH_LABEL;
        end else begin
          // any other byte opens an image descriptor at its separator
          field_counter_next = 4'd1;
          phase_next         = PH_IMD;
        end
      end
      PH_LABEL: begin
        field_counter_next = 4'd0;
        priority case (b)
          LBL_PTEXT:   phase_next = PH_PT;
          LBL_GCTRL:   phase_next = PH_GCE;
          LBL_APP:     phase_next = PH_APP;
          LBL_COMMENT: phase_next = PH_COM_LEN;
          default: begin
            error_latch_next = 1'b1;
            phase_next       = PH_ERR;
          end
        endcase
      end
      PH_PT: begin
        if (lay_end) phase_next = PH_PT_LEN;
      end
      PH_GCE: begin
        if (lay_end) phase_next = PH_SELECT;
      end
      PH_APP: begin
        if (lay_end) phase_next = PH_APP_LEN;
      end
      PH_IMD: begin
        if (field_counter == IMD_PACKED_POS) begin
          table_entries_next = table_size(b);
        end
        if (lay_end) begin
          tab_entry_next = 8'd0;
          tab_part_next  = 2'd0;
          phase_next     = (table_entries_next != 9'd0) ? PH_LTAB : PH_LZW;
        end
      end
      PH_PT_LEN, PH_APP_LEN, PH_COM_LEN, PH_IMG_LEN: begin
        if (b == 8'd0) begin
          unique case (phase)
            PH_PT_LEN:  phase_next = PH_SELECT;
            PH_APP_LEN: phase_next = PH_SELECT;
            PH_COM_LEN: phase_next = PH_SELECT;
            default:    phase_next = PH_AFTER_IMG;
          endcase
        end else begin
          sub_block_left_next = b;
          unique case (phase)
            PH_PT_LEN:  phase_next = PH_PT_DATA;
            PH_APP_LEN: phase_next = PH_APP_DATA;
            PH_COM_LEN: phase_next = PH_COM_DATA;
            default:    phase_next = PH_IMG_DATA;
          endcase
        end
      end
      PH_PT_DATA, PH_APP_DATA, PH_COM_DATA, PH_IMG_DATA: begin
        sub_block_left_next = sub_block_left - 8'd1;
        if (sub_block_left == 8'd1) begin
          unique case (phase)
            PH_PT_DATA:  phase_next = PH_PT_LEN;
            PH_APP_DATA: phase_next = PH_APP_LEN;
            PH_COM_DATA: phase_next = PH_COM_LEN;
            default:     phase_next = PH_IMG_LEN;
          endcase
        end
      end
      PH_LZW: begin
        phase_next = PH_IMG_LEN;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // tag of the current byte
  always_comb begin
    logic [3:0] len_code;
    logic [3:0] chain_sec;
    len_code  = FC_IMG_LEN;
    chain_sec = SEC_IMGDATA;
    t_section = SEC_ERROR;
    t_code    = FC_NONE;
    t_value   = {8'd0, b};
    t_done    = 1'b1;
    t_sbd     = 1'b0;
    t_cend    = 1'b0;

    unique case (phase)
      PH_PT_LEN, PH_PT_DATA: begin
        len_code  = FC_PT_LEN;
        chain_sec = SEC_PTEXT;
      end
      PH_APP_LEN, PH_APP_DATA: begin
        len_code  = FC_APP_LEN;
        chain_sec = SEC_APP;
      end
      PH_COM_LEN, PH_COM_DATA: begin
        len_code  = FC_COM_LEN;
        chain_sec = SEC_COMMENT;
      end
      default: begin
        len_code  = FC_IMG_LEN;
        chain_sec = SEC_IMGDATA;
      end
    endcase

    unique case (phase)
      PH_HDR: begin
        t_section = SEC_HEADER;
      end
      PH_LSD, PH_PT, PH_GCE, PH_APP, PH_IMD, PH_SELECT, PH_AFTER_IMG: begin
        unique case (phase)
          PH_LSD:  t_section = SEC_SCREEN;
          PH_PT:   t_section = SEC_PTEXT;
          PH_GCE:  t_section = SEC_GCTRL;
          PH_APP:  t_section = SEC_APP;
          default: t_section = SEC_IMGDESC;
        endcase
        t_code = lay[3:0];
        if (lay[KIND_LOW]) begin
          t_done = 1'b0;
        end else if (lay[KIND_HIGH]) begin
          t_value = {b, low_byte_hold};
        end
        t_cend = lay[KIND_TERM];
        if (phase == PH_AFTER_IMG && b == BYTE_TRAILER) begin
          t_section = SEC_TRAILER;
          t_code    = FC_NONE;
        end else if ((phase == PH_SELECT || phase == PH_AFTER_IMG) && blk_intro) begin
          t_section = SEC_EXT;
          t_code    = FC_EXT_INTRO;
        end
      end
      PH_GTAB, PH_LTAB: begin
        t_section = SEC_TABLE;
        t_code    = (phase == PH_GTAB) ? FC_TAB_GLOBAL : FC_TAB_LOCAL;
      end
      PH_LABEL: begin
        t_section = SEC_EXT;
        t_code    = FC_EXT_LABEL;
      end
      PH_PT_LEN, PH_APP_LEN, PH_COM_LEN, PH_IMG_LEN: begin
        t_section = chain_sec;
        if (b == 8'd0) begin
          t_code = len_code + FC_TERM_OFS;
          t_cend = 1'b1;
        end else begin
          t_code = len_code;
        end
      end
      PH_PT_DATA, PH_APP_DATA, PH_COM_DATA, PH_IMG_DATA: begin
        t_section = chain_sec;
        t_code    = len_code + FC_DATA_OFS;
        t_sbd     = 1'b1;
      end
      PH_LZW: begin
        t_section = SEC_IMGDATA;
        t_code    = FC_LZW_MIN;
      end
      PH_DONE: begin
        t_section = SEC_DONE;
        t_value   = 16'd0;
        t_done    = 1'b0;
      end
      default: begin
        t_section = SEC_ERROR;
        t_value   = 16'd0;
        t_done    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR;
      field_counter  <= 4'd0;
      tab_entry      <= 8'd0;
      tab_part       <= 2'd0;
      table_entries  <= 9'd0;
      sub_block_left <= 8'd0;
      low_byte_hold  <= 8'd0;
      error_latch    <= 1'b0;
      done_latch     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        field_counter  <= field_counter_next;
        tab_entry      <= tab_entry_next;
        tab_part       <= tab_part_next;
        table_entries  <= table_entries_next;
        sub_block_left <= sub_block_left_next;
        low_byte_hold  <= low_byte_hold_next;
        error_latch    <= error_latch_next;
        done_latch     <= done_latch_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_byte       <= b;
      section        <= t_section;
      field_code     <= t_code;
      field_value    <= t_value;
      value_done     <= t_done;
      table_entry    <= (phase == PH_GTAB || phase == PH_LTAB) ? tab_entry : 8'd0;
      color_part     <= (phase == PH_GTAB || phase == PH_LTAB) ? tab_part : 2'd0;
      sub_block_data <= t_sbd;
      chain_end      <= t_cend;
      bad_label      <= error_latch_next;
      stream_done    <= done_latch_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gcbp_checker.sv
// ----------------------------------------------------------------------------
// gcbp_checker
// Port-level checks on the GIF block structure parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gcbp_checker
  import gcbp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  raw_byte,
  input wire logic [3:0]  section,
  input wire logic [3:0]  field_code,
  input wire logic [15:0] field_value,
  input wire logic        value_done,
  input wire logic        sub_block_data,
  input wire logic        chain_end,
  input wire logic        bad_label,
  input wire logic        stream_done
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(raw_byte) && $stable(section))
    else $error("stalled item changed");

  // once the trailer is seen only trailer or finished tags appear
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> section == SEC_TRAILER || section == SEC_DONE)
    else $error("tag after trailer");

  // the error flag goes with the bad label byte or the error section
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_label |->
      section == SEC_ERROR || (section == SEC_EXT && field_code == FC_EXT_LABEL))
    else $error("bad label flag outside error");

  // an unfinished value never carries a high byte
  a_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !value_done |-> field_value[15:8] == 8'h00)
    else $error("partial value with high byte");

  // payload bytes are complete and never terminate a chain
  a_sbd: assert property (@(posedge clk) disable iff (rst)
    out_valid && sub_block_data |-> !chain_end && value_done)
    else $error("payload byte marked as terminator");

endmodule

bind gif_container_block_parser gcbp_checker u_gcbp_checker (.*);

`default_nettype wire
